[hdl/miller_rabin_prime_test_macros.svh]
// Assertion macros for the primality test block.
`ifndef MILLER_RABIN_PRIME_TEST_MACROS_SVH
`define MILLER_RABIN_PRIME_TEST_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define MRPT_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// The consequent must hold at the same edge as the antecedent.
`define MRPT_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// The consequent must hold at the edge after the antecedent.
`define MRPT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/mrpt_pkg.sv]
package mrpt_pkg;

   localparam int NUMBER_WIDTH_DEF = 63;
   localparam int BASE_COUNT_DEF   = 12;
   localparam int BASE_TABLE_SIZE  = 12;
   localparam int BASE_IDX_WIDTH   = 4;
   localparam int BASE_VAL_WIDTH   = 6;

   function automatic logic [BASE_VAL_WIDTH-1:0] base_value(
      input logic [BASE_IDX_WIDTH-1:0] idx
   );
      logic [BASE_VAL_WIDTH-1:0] val;
      case (idx)
         4'd0:    val = 6'd2;
         4'd1:    val = 6'd3;
         4'd2:    val = 6'd5;
         4'd3:    val = 6'd7;
         4'd4:    val = 6'd11;
         4'd5:    val = 6'd13;
         4'd6:    val = 6'd17;
         4'd7:    val = 6'd19;
         4'd8:    val = 6'd23;
         4'd9:    val = 6'd29;
         4'd10:   val = 6'd31;
         4'd11:   val = 6'd37;
         default: val = 6'd2;
      endcase
      return val;
   endfunction

endpackage

[hdl/miller_rabin_prime_test.sv]
// Deterministic Miller-Rabin primality test. Each item is a candidate below
// 2^NUMBER_WIDTH and yields one item with prime_flag set when the candidate is
// prime; zero and one are reported as not prime. The block works on one item
// at a time and holds req_ready low until the result has been taken. All
// modular multiplications run through one shift-and-add modular multiplier
// that retires one multiplier bit per cycle. A base costs about (bit length
// of d plus its set bits plus r - 1) multiplications, where n - 1 = d * 2^r,
// and the test stops at the first base that proves the candidate composite.
// For candidates below two the result is valid in the cycle after the
// candidate is taken.
`include "miller_rabin_prime_test_macros.svh"

module miller_rabin_prime_test
   import mrpt_pkg::*;
#(
   parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF,
   parameter int BASE_COUNT   = BASE_COUNT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [NUMBER_WIDTH-1:0] req_candidate,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_prime_flag
);

   localparam int W  = NUMBER_WIDTH;
   localparam int CW = $clog2(NUMBER_WIDTH);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_TZ     = 8'b0000_0010,
      ST_BASE   = 8'b0000_0100,
      ST_REDUCE = 8'b0000_1000,
      ST_POW    = 8'b0001_0000,
      ST_MUL    = 8'b0010_0000,
      ST_SQR    = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   typedef enum logic [1:0] {
      MD_ACC = 2'd0,
      MD_SQB = 2'd1,
      MD_SQX = 2'd2
   } mul_dest_type;

   state_type                 state_ff, state_in;
   mul_dest_type              dest_ff, dest_in;
   logic [W-1:0]              n_ff, n_in;
   logic [W-1:0]              d_ff, d_in;
   logic [W-1:0]              e_ff, e_in;
   logic [W-1:0]              acc_ff, acc_in;
   logic [W-1:0]              b_ff, b_in;
   logic [W-1:0]              macc_ff, macc_in;
   logic [CW-1:0]             r_ff, r_in;
   logic [CW-1:0]             sq_left_ff, sq_left_in;
   logic [CW-1:0]             bit_ff, bit_in;
   logic [BASE_IDX_WIDTH-1:0] idx_ff, idx_in;
   logic                      result_ff, result_in;

   logic [W:0]                n_ext;
   logic [W:0]                dbl;
   logic [W:0]                dbl_sub;
   logic [W-1:0]              dbl_red;
   logic [W:0]                sum;
   logic [W:0]                sum_sub;
   logic [W-1:0]              mul_res;
   logic [W-1:0]              mul_a;
   logic [W-1:0]              mul_src;
   logic                      mul_bit;
   logic [W-1:0]              n_minus_one;
   logic [W-1:0]              base_ext;
   logic                      base_pass;

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = (state_ff == ST_DONE);
   assign rsp_prime_flag = result_ff;

   assign n_ext       = {1'b0, n_ff};
   assign n_minus_one = n_ff - W'(1);
   assign base_ext    = W'(base_value(idx_ff));

   // One step of the shift-and-add modular multiplier.
   always_comb begin
      case (dest_ff)
         MD_ACC: begin
            mul_a   = acc_ff;
            mul_src = b_ff;
         end
         MD_SQB: begin
            mul_a   = b_ff;
            mul_src = b_ff;
         end
         MD_SQX: begin
            mul_a   = acc_ff;
            mul_src = acc_ff;
         end
         default: begin
            mul_a   = acc_ff;
            mul_src = acc_ff;
         end
      endcase
      mul_bit = mul_src[bit_ff];
      dbl     = {macc_ff, 1'b0};
      dbl_sub = dbl - n_ext;
      dbl_red = (dbl >= n_ext) ? dbl_sub[W-1:0] : dbl[W-1:0];
      sum     = {1'b0, dbl_red} + (mul_bit ? {1'b0, mul_a} : {(W+1){1'b0}});
      sum_sub = sum - n_ext;
      mul_res = (sum >= n_ext) ? sum_sub[W-1:0] : sum[W-1:0];
   end

   always_comb begin
      state_in   = state_ff;
      dest_in    = dest_ff;
      n_in       = n_ff;
      d_in       = d_ff;
      e_in       = e_ff;
      acc_in     = acc_ff;
      b_in       = b_ff;
      macc_in    = macc_ff;
      r_in       = r_ff;
      sq_left_in = sq_left_ff;
      bit_in     = bit_ff;
      idx_in     = idx_ff;
      result_in  = result_ff;
      base_pass  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               n_in = req_candidate;
               d_in = req_candidate - W'(1);
               r_in = '0;
               if (req_candidate < W'(2)) begin
                  result_in = 1'b0;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_TZ;
               end
            end
         end
         ST_TZ: begin
            if (!d_ff[0]) begin
               d_in = d_ff >> 1;
               r_in = r_ff + CW'(1);
            end else begin
               idx_in   = '0;
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            if (n_ff == base_ext) begin
               result_in = 1'b1;
               state_in  = ST_DONE;
            end else begin
               b_in     = base_ext;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (b_ff >= n_ff) begin
               b_in = b_ff - n_ff;
            end else begin
               acc_in   = W'(1);
               e_in     = d_ff;
               state_in = ST_POW;
            end
         end
         ST_POW: begin
            macc_in = '0;
            bit_in  = CW'(W - 1);
            if (e_ff == '0) begin
               if (acc_ff == W'(1) || acc_ff == n_minus_one) begin
                  base_pass = 1'b1;
               end else begin
                  sq_left_in = (r_ff == '0) ? '0 : r_ff - CW'(1);
                  state_in   = ST_SQR;
               end
            end else if (e_ff[0]) begin
               dest_in  = MD_ACC;
               state_in = ST_MUL;
            end else begin
               dest_in  = MD_SQB;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            macc_in = mul_res;
            bit_in  = bit_ff - CW'(1);
            if (bit_ff == '0) begin
               case (dest_ff)
                  MD_ACC: begin
                     acc_in = mul_res;
                     if (e_ff == W'(1)) begin
                        e_in     = '0;
                        state_in = ST_POW;
                     end else begin
                        macc_in = '0;
                        bit_in  = CW'(W - 1);
                        dest_in = MD_SQB;
                     end
                  end
                  MD_SQB: begin
                     b_in     = mul_res;
                     e_in     = e_ff >> 1;
                     state_in = ST_POW;
                  end
                  MD_SQX: begin
                     acc_in = mul_res;
                     if (mul_res == n_minus_one) begin
                        base_pass = 1'b1;
                     end else begin
                        state_in = ST_SQR;
                     end
                  end
                  default: begin
                     state_in = ST_POW;
                  end
               endcase
            end
         end
         ST_SQR: begin
            if (sq_left_ff == '0) begin
               result_in = 1'b0;
               state_in  = ST_DONE;
            end else begin
               sq_left_in = sq_left_ff - CW'(1);
               macc_in    = '0;
               bit_in     = CW'(W - 1);
               dest_in    = MD_SQX;
               state_in   = ST_MUL;
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A base that fails to prove the candidate composite moves on to the next; the last reports prime.
      if (base_pass) begin
         if (idx_ff == BASE_IDX_WIDTH'(BASE_COUNT - 1)) begin
            result_in = 1'b1;
            state_in  = ST_DONE;
         end else begin
            idx_in   = idx_ff + BASE_IDX_WIDTH'(1);
            state_in = ST_BASE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dest_ff  <= MD_ACC;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         dest_ff  <= dest_in;
         idx_ff   <= idx_in;
      end
      n_ff       <= n_in;
      d_ff       <= d_in;
      e_ff       <= e_in;
      acc_ff     <= acc_in;
      b_ff       <= b_in;
      macc_ff    <= macc_in;
      r_ff       <= r_in;
      sq_left_ff <= sq_left_in;
      bit_ff     <= bit_in;
      result_ff  <= result_in;
   end

   `MRPT_ASSERT_ALWAYS(a_ready_result_excl, !(req_ready && rsp_valid), "ready while result pending")
   `MRPT_ASSERT_SAME(a_mul_acc_reduced, state_ff == ST_MUL, macc_ff < n_ff, "multiplier acc not reduced")
   `MRPT_ASSERT_SAME(a_pow_reduced, state_ff == ST_POW, (acc_ff < n_ff) && (b_ff < n_ff), "operand not reduced")
   `MRPT_ASSERT_SAME(a_tz_nonzero, state_ff == ST_TZ, d_ff != '0, "zero value in factor-of-two stripping")
   `MRPT_ASSERT_NEXT(a_small_not_prime, req_valid && req_ready && (req_candidate < W'(2)), rsp_valid && !rsp_prime_flag, "small candidate not answered")

endmodule
